/* design/hex_record_loader_assert.svh */
// Assertion macros shared by the loader RTL.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef HEX_RECORD_LOADER_ASSERT_SVH
`define HEX_RECORD_LOADER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check under reset: disabled while rst_n is low.
`define HRL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check at every edge, reset included.
`define HRL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HRL_ASSERT(label, clk, rst_n, prop, msg)
`define HRL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* design/hrl_pkg.sv */
// Shared types, character codes and the hex digit decoder of the loader.
// No dependencies.
package hrl_pkg;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Upper offsets and index bias used by the config mapping rules
  localparam logic [15:0] OFFSET_CFG_LOW  = 16'h0001;
  localparam logic [15:0] OFFSET_CFG_HIGH = 16'h0030;
  localparam logic [16:0] CFG_ADDR_BIAS   = 17'h0000E;

  localparam logic [7:0] REC_DATA   = 8'h00;
  localparam logic [7:0] REC_OFFSET = 8'h04;

  // Register indexes of the write port
  localparam logic [1:0] REG_FLASH_SIZE   = 2'd0;
  localparam logic [1:0] REG_CFG_AREA     = 2'd1;
  localparam logic [1:0] REG_FAMILY_GROUP = 2'd2;

  typedef enum logic [1:0] {
    FAM_OFFSET_LOW  = 2'd0,
    FAM_OFFSET_HIGH = 2'd1,
    FAM_END_FLASH   = 2'd2,
    FAM_NONE        = 2'd3
  } family_e;

  typedef struct packed {
    logic        pm_write;
    logic [16:0] pm_address;
    logic        cfg_write;
    logic [3:0]  cfg_index;
  } target_t;

  // Returns {valid, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage

/* design/hrl_target.sv */
// Address mapping of one data byte to program memory and config area.
// Depends on hrl_pkg.
module hrl_target #(
  parameter int unsigned PROGMEM_BYTES = 131072,
  parameter int unsigned CFG_SLOTS     = 16
) (
  input  logic [15:0]           upper_offset_i,
  input  logic [15:0]           record_address_i,
  input  logic [7:0]            byte_index_i,
  input  logic [17:0]           flash_size_i,
  input  logic [4:0]            cfg_area_size_i,
  input  hrl_pkg::family_e      family_group_i,
  output hrl_pkg::target_t      target_o
);
  import hrl_pkg::*;

  localparam int unsigned PmLimit  = (PROGMEM_BYTES < 131072) ? PROGMEM_BYTES : 131072;
  localparam int unsigned CfgLimit = (CFG_SLOTS < 16) ? CFG_SLOTS : 16;

  logic [31:0] base;
  logic [32:0] addr_sum;
  logic [16:0] low_sum;
  logic [17:0] end_base;
  logic        pm_hit;
  logic        cfg_hit;
  logic [16:0] cfg_idx;
  logic        cfg_ok;

  assign base     = {upper_offset_i, record_address_i};
  assign addr_sum = {1'b0, base} + {25'b0, byte_index_i};
  assign low_sum  = {1'b0, record_address_i} + {9'b0, byte_index_i};
  assign end_base = flash_size_i - {13'b0, cfg_area_size_i};

  assign pm_hit = (base < {14'b0, flash_size_i}) && (addr_sum < 33'(PmLimit));

  always_comb begin
    cfg_hit = 1'b0;
    cfg_idx = {9'b0, byte_index_i};
    unique case (family_group_i)
      FAM_OFFSET_LOW: begin
        cfg_hit = (upper_offset_i == OFFSET_CFG_LOW) && (low_sum >= CFG_ADDR_BIAS);
        cfg_idx = low_sum - CFG_ADDR_BIAS;
      end
      FAM_OFFSET_HIGH: cfg_hit = (upper_offset_i == OFFSET_CFG_HIGH);
      FAM_END_FLASH: begin
        // no record matches when the area is larger than the flash
        cfg_hit = (flash_size_i >= {13'b0, cfg_area_size_i}) && (base == {14'b0, end_base});
      end
      default: cfg_hit = 1'b0;
    endcase
  end

  assign cfg_ok = cfg_hit && (cfg_idx < 17'(CfgLimit));

  assign target_o.pm_write   = pm_hit;
  assign target_o.pm_address = pm_hit ? addr_sum[16:0] : 17'b0;
  assign target_o.cfg_write  = cfg_ok;
  assign target_o.cfg_index  = cfg_ok ? cfg_idx[3:0] : 4'b0;

endmodule

/* design/hex_record_loader.sv */
// Streaming HEX record loader. One character is taken per clock; a request is
// accepted whenever the result register is empty or being drained in the same
// cycle, so a steady stream runs at one character per cycle and each result is
// registered in the next cycle. The per-character work (digit decode,
// field shift, address compare for a data byte) sits between the input and the
// single result register. Characters that write nothing produce no result; a
// malformed line produces one error result and freezes the parser until reset.
// Depends on hrl_pkg, hrl_target and hex_record_loader_assert.svh.
`include "hex_record_loader_assert.svh"

module hex_record_loader #(
  parameter int unsigned PROGMEM_BYTES = 131072,
  parameter int unsigned CFG_SLOTS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        reg_we_i,
  input  logic [1:0]  reg_idx_i,
  input  logic [17:0] reg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pm_write_o,
  output logic [16:0] pm_address_o,
  output logic        cfg_write_o,
  output logic [3:0]  cfg_index_o,
  output logic [7:0]  data_byte_o,
  output logic        parse_error_o
);
  import hrl_pkg::*;

  logic [17:0] flash_size_q;
  logic [4:0]  cfg_area_q;
  family_e     family_q;

  logic [9:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] upper_q, upper_d;
  logic [3:0]  hi_q, hi_d;
  logic [7:0]  byte_idx_q, byte_idx_d;
  logic        err_q, err_d;

  logic        out_valid_q;
  logic        pm_write_q, cfg_write_q, parse_error_q;
  logic [16:0] pm_address_q;
  logic [3:0]  cfg_index_q;
  logic [7:0]  data_byte_q;

  logic        in_accept;
  logic [4:0]  nib;
  logic [9:0]  data_end;
  logic        raise;
  logic        emit;
  target_t     tgt;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign nib        = hex_nibble(ch_i);
  assign data_end   = 10'd9 + {1'b0, len_q, 1'b0};

  hrl_target #(
    .PROGMEM_BYTES(PROGMEM_BYTES),
    .CFG_SLOTS    (CFG_SLOTS)
  ) u_target (
    .upper_offset_i  (upper_q),
    .record_address_i(addr_q),
    .byte_index_i    (byte_idx_q),
    .flash_size_i    (flash_size_q),
    .cfg_area_size_i (cfg_area_q),
    .family_group_i  (family_q),
    .target_o        (tgt)
  );

  always_comb begin
    pos_d      = pos_q;
    len_d      = len_q;
    addr_d     = addr_q;
    type_d     = type_q;
    upper_d    = upper_q;
    hi_d       = hi_q;
    byte_idx_d = byte_idx_q;
    err_d      = err_q;
    raise      = 1'b0;
    emit       = 1'b0;
    if (in_accept && !err_q) begin
      if (pos_q == 10'd0) begin
        if (ch_i != CHAR_COLON) begin
          raise = 1'b1;
        end else begin
          byte_idx_d = 8'd0;
          pos_d      = 10'd1;
        end
      end else if (ch_i == CHAR_NEWLINE) begin
        pos_d      = 10'd0;
        byte_idx_d = 8'd0;
      end else begin
        if (pos_q <= 10'd8) begin
          if (!nib[4]) raise = 1'b1;
          else if (pos_q <= 10'd2) len_d = {len_q[3:0], nib[3:0]};
          else if (pos_q <= 10'd6) addr_d = {addr_q[11:0], nib[3:0]};
          else type_d = {type_q[3:0], nib[3:0]};
        end else if (type_q == REC_DATA) begin
          if (pos_q < data_end) begin
            if (!nib[4]) begin
              raise = 1'b1;
            end else if (pos_q[0]) begin
              hi_d = nib[3:0];
            end else begin
              emit       = tgt.pm_write || tgt.cfg_write;
              byte_idx_d = byte_idx_q + 8'd1;
            end
          end
        end else if (type_q == REC_OFFSET) begin
          if (pos_q <= 10'd12) begin
            // first offset digit starts a fresh value, a short line keeps it
            if (!nib[4]) raise = 1'b1;
            else if (pos_q == 10'd9) upper_d = {12'b0, nib[3:0]};
            else upper_d = {upper_q[11:0], nib[3:0]};
          end
        end
        // hold position on error, saturate on long lines
        if (!raise && pos_q != 10'h3FF) pos_d = pos_q + 10'd1;
      end
      if (raise) err_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_size_q <= 18'd0;
      cfg_area_q   <= 5'd0;
      family_q     <= FAM_NONE;
    end else if (reg_we_i) begin
      unique case (reg_idx_i)
        REG_FLASH_SIZE:   flash_size_q <= reg_wdata_i;
        REG_CFG_AREA:     cfg_area_q   <= reg_wdata_i[4:0];
        REG_FAMILY_GROUP: family_q     <= family_e'(reg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 10'd0;
      len_q      <= 8'd0;
      addr_q     <= 16'd0;
      type_q     <= 8'd0;
      upper_q    <= 16'd0;
      hi_q       <= 4'd0;
      byte_idx_q <= 8'd0;
      err_q      <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      len_q      <= len_d;
      addr_q     <= addr_d;
      type_q     <= type_d;
      upper_q    <= upper_d;
      hi_q       <= hi_d;
      byte_idx_q <= byte_idx_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (raise || emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (raise) begin
      pm_write_q    <= 1'b0;
      pm_address_q  <= 17'd0;
      cfg_write_q   <= 1'b0;
      cfg_index_q   <= 4'd0;
      data_byte_q   <= 8'd0;
      parse_error_q <= 1'b1;
    end else if (emit) begin
      pm_write_q    <= tgt.pm_write;
      pm_address_q  <= tgt.pm_address;
      cfg_write_q   <= tgt.cfg_write;
      cfg_index_q   <= tgt.cfg_index;
      data_byte_q   <= {hi_q, nib[3:0]};
      parse_error_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pm_write_o    = pm_write_q;
  assign pm_address_o  = pm_address_q;
  assign cfg_write_o   = cfg_write_q;
  assign cfg_index_o   = cfg_index_q;
  assign data_byte_o   = data_byte_q;
  assign parse_error_o = parse_error_q;

  `HRL_ASSERT(a_err_sticky, clk_i, rst_ni, err_q |=> err_q, "error flag cleared without reset")
  `HRL_ASSERT(a_err_result, clk_i, rst_ni, $rose(err_q) |-> out_valid_q && parse_error_q, "error raised without error result")
  `HRL_ASSERT(a_data_has_target, clk_i, rst_ni, out_valid_q && !parse_error_q |-> pm_write_q || cfg_write_q, "data result writes nowhere")
  `HRL_ASSERT(a_err_clean, clk_i, rst_ni, out_valid_q && parse_error_q |-> !pm_write_q && !cfg_write_q && data_byte_q == 8'd0, "error result carries data")
  `HRL_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule
